[rtl/wsg_pkg.sv]
// Shared types and constants of the waveform shape generator.
// No dependencies; every other file but wsg_isqrt uses this package.
package wsg_pkg;

  localparam int PHASE_W        = 16;
  localparam int SAMPLE_W       = 16;
  localparam int SHAPE_W        = 3;
  localparam int PHASE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_TRI,
    SHAPE_SAW,
    SHAPE_SQUARE,
    SHAPE_PARAB,
    SHAPE_ROOT,
    SHAPE_SOFT,
    SHAPE_BIPOLAR,
    SHAPE_SEMI
  } shape_t;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_ROOT,
    KIND_SEMI_POS,
    KIND_SEMI_NEG
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  direct;
  } side_t;

endpackage

[rtl/wsg_phase_if.sv]
// Phase request channel (valid/ready plus phase payload).
// Depends on wsg_pkg.
interface wsg_phase_if;
  logic                         valid;
  logic                         ready;
  logic [wsg_pkg::PHASE_W-1:0]  phase_in;
  modport source (output valid, output phase_in, input ready);
  modport sink   (input valid, input phase_in, output ready);
endinterface

[rtl/wsg_sample_if.sv]
// Sample result channel (valid/ready plus signed sample payload).
// Depends on wsg_pkg.
interface wsg_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wsg_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/wsg_cfg_if.sv]
// Configuration write channel carrying the shape register value.
// Depends on wsg_pkg.
interface wsg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wsg_pkg::SHAPE_W-1:0]  shape_select;
  modport source (output valid, output shape_select, input ready);
  modport sink   (input valid, input shape_select, output ready);
endinterface

[rtl/wsg_front.sv]
// Front end: phase folding and scaling (stage 1), squaring and radicand (stage 2).
// Depends on wsg_pkg.
module wsg_front #(
  parameter int PHASE_BITS = wsg_pkg::PHASE_BITS_DEF,
  parameter int FRAC_BITS  = wsg_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [wsg_pkg::PHASE_W-1:0]   phase,
  input  wsg_pkg::shape_t               shape,
  output logic                          out_valid,
  output logic [2*FRAC_BITS+1:0]        rad,
  output wsg_pkg::side_t                side
);
  import wsg_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int FB = FRAC_BITS;
  localparam int SW = PB + FB + 3;
  localparam int VW = FB + 3;
  localparam int RW = 2 * FB + 2;

  localparam logic [PB:0]          TURN1   = {1'b1, {PB{1'b0}}};
  localparam logic [PB-1:0]        HALF_PH = PB'(1) << (PB - 1);
  localparam logic [PB-1:0]        QTR_PH  = PB'(1) << (PB - 2);
  localparam logic [PB-1:0]        A_PH    = PB'(3) << (PB - 3);
  localparam logic [PB-1:0]        B_PH    = PB'(7) << (PB - 3);
  localparam logic [SW-1:0]        HALF_R  = SW'(1) << (PB - 1);
  localparam logic [SW-1:0]        RND_R   = SW'(1) << (PB - 4);
  localparam logic [PB+1:0]        C_LO    = (PB+2)'(1) << PB;
  localparam logic [PB+1:0]        C_HI    = (PB+2)'(3) << PB;
  localparam logic [FB:0]          ONE_U   = (FB+1)'(1) << FB;
  localparam logic signed [VW-1:0] ONE_V   = {3'b001, {FB{1'b0}}};
  localparam logic signed [VW-1:0] HALF_V  = {4'b0001, {(FB-1){1'b0}}};
  localparam logic [RW-1:0]        ONE_SQ  = RW'(1) << (2 * FB);
  localparam logic [RW-1:0]        RND_SQ  = RW'(1) << (FB - 1);

  logic [PB-1:0]        p;
  logic [PB:0]          p2, t;
  logic [SW-1:0]        d_w, saw_w, r1_w, r2_w, y_w;
  logic [FB:0]          d, y;
  logic                 neg, in_r1, in_r2, upper;
  logic [PB-1:0]        w;
  logic [PB+1:0]        w4, c, span;
  logic signed [VW-1:0] v_tri, v_saw, v_soft, val1;

  assign p     = PB'(phase);
  assign p2    = {p, 1'b0};
  assign t     = (p2 >= TURN1) ? p2 - TURN1 : TURN1 - p2;
  assign d_w   = ((SW'(t) << FB) + HALF_R) >> PB;
  assign d     = d_w[FB:0];
  assign saw_w = ((SW'(p2) << FB) + HALF_R) >> PB;
  assign neg   = p[PB-1];
  assign v_tri = signed'(VW'({d, 1'b0})) - ONE_V;
  assign v_saw = ONE_V - signed'(saw_w[VW-1:0]);

  assign in_r1  = (p >= A_PH) && (p <= HALF_PH);
  assign in_r2  = (p >= B_PH);
  assign r1_w   = ((SW'(p - A_PH) << (FB + 1)) + RND_R) >> (PB - 3);
  assign r2_w   = ((SW'(p - B_PH) << (FB + 1)) + RND_R) >> (PB - 3);
  assign v_soft = in_r1 ? ONE_V - signed'(r1_w[VW-1:0]) :
                  in_r2 ? signed'(r2_w[VW-1:0]) - ONE_V :
                  (neg ? -ONE_V : ONE_V);

  assign w     = p + QTR_PH;
  assign upper = (w <= HALF_PH);
  assign w4    = {w, 2'b00};
  assign c     = upper ? C_LO : C_HI;
  assign span  = (w4 >= c) ? w4 - c : c - w4;
  assign y_w   = ((SW'(span) << FB) + HALF_R) >> PB;
  assign y     = (y_w > SW'(ONE_U)) ? ONE_U : y_w[FB:0];

  always_comb begin
    case (shape)
      SHAPE_TRI:     val1 = v_tri;
      SHAPE_SAW:     val1 = v_saw;
      SHAPE_SQUARE:  val1 = neg ? -HALF_V : HALF_V;
      SHAPE_SOFT:    val1 = v_soft;
      SHAPE_BIPOLAR: val1 = neg ? -ONE_V : ONE_V;
      default:       val1 = v_tri;
    endcase
  end

  logic                 s1_valid;
  shape_t               s1_sel;
  logic [FB:0]          s1_d, s1_y;
  logic                 s1_upper;
  logic signed [VW-1:0] s1_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_sel   <= shape;
      s1_d     <= d;
      s1_y     <= y;
      s1_upper <= upper;
      s1_val   <= val1;
    end
  end

  logic [RW-1:0]        dd, yy, sq_w, rad_next;
  logic [FB:0]          sq;
  logic signed [VW-1:0] v_par;
  side_t                side_next;

  assign dd    = RW'(s1_d) * RW'(s1_d);
  assign yy    = RW'(s1_y) * RW'(s1_y);
  assign sq_w  = (dd + RND_SQ) >> FB;
  assign sq    = sq_w[FB:0];
  assign v_par = signed'(VW'({sq, 1'b0})) - ONE_V;

  always_comb begin
    side_next.direct = SAMPLE_W'(s1_val);
    rad_next         = RW'(s1_d) << FB;
    case (s1_sel)
      SHAPE_PARAB: begin
        side_next.kind   = KIND_DIRECT;
        side_next.direct = SAMPLE_W'(v_par);
      end
      SHAPE_ROOT: begin
        side_next.kind = KIND_ROOT;
      end
      SHAPE_SEMI: begin
        side_next.kind = s1_upper ? KIND_SEMI_POS : KIND_SEMI_NEG;
        rad_next       = ONE_SQ - yy;
      end
      default: begin
        side_next.kind = KIND_DIRECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
    if (en) begin
      rad  <= rad_next;
      side <= side_next;
    end
  end

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_d <= ONE_U) && (s1_y <= ONE_U))
    else $error("folded phase exceeds unity");

endmodule

[rtl/wsg_isqrt.sv]
// Pipelined integer square root, one result bit per register stage, with a tag
// travelling alongside. Depends on nothing but its parameters.
module wsg_isqrt #(
  parameter int RAD_W = 30,
  parameter int TAG_W = 18
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [RAD_W-1:0]       rad_in,
  input  logic [TAG_W-1:0]       tag_in,
  output logic                   out_valid,
  output logic [RAD_W/2-1:0]     root_out,
  output logic [TAG_W-1:0]       tag_out
);
  localparam int N     = RAD_W / 2;
  localparam int REM_W = N + 3;

  logic             vld  [N];
  logic [RAD_W-1:0] rad  [N];
  logic [REM_W-1:0] rem  [N];
  logic [N-1:0]     root [N];
  logic [TAG_W-1:0] tag  [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             pv;
    logic [RAD_W-1:0] prad;
    logic [REM_W-1:0] prem, rsh, trial;
    logic [N-1:0]     proot;
    logic [TAG_W-1:0] ptag;
    logic             ge;

    if (k == 0) begin : g_in
      assign pv    = in_valid;
      assign prad  = rad_in;
      assign prem  = '0;
      assign proot = '0;
      assign ptag  = tag_in;
    end else begin : g_chain
      assign pv    = vld[k-1];
      assign prad  = rad[k-1];
      assign prem  = rem[k-1];
      assign proot = root[k-1];
      assign ptag  = tag[k-1];
    end

    assign rsh   = {prem[REM_W-3:0], prad[RAD_W-1:RAD_W-2]};
    assign trial = REM_W'({proot, 2'b01});
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
      if (en) begin
        rad[k]  <= prad << 2;
        rem[k]  <= ge ? rsh - trial : rsh;
        root[k] <= {proot[N-2:0], ge};
        tag[k]  <= ptag;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign root_out  = root[N-1];
  assign tag_out   = tag[N-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[N-1] |-> (rem[N-1] <= REM_W'({root[N-1], 1'b0})))
    else $error("square root remainder exceeds twice the root");

endmodule

[rtl/waveform_shape_generator_core.sv]
// Waveform shape generator top level: front end, square root pipeline, output register.
// Depends on wsg_pkg, the channel interfaces, wsg_front and wsg_isqrt.
//
// Use: each request on the phase channel carries one phase, a fraction of a
// turn. One signed sample per request leaves on the sample channel, in the
// order taken. The cfg channel writes the 3-bit shape register; it is always
// ready and should be written only while no request is in flight.
// From phase acceptance to sample valid, a request passes two front-end stages,
// one stage per root bit in the square root pipeline, and the output register.
// Throughput: one request per cycle, set by the fully pipelined root unit, while
// the receiver takes samples (see below).
// Reset (synchronous, rst high) clears all valid bits and sets the shape to
// triangle. When the receiver holds ready low with a sample waiting, the
// whole pipeline holds and phase ready drops; nothing is dropped or repeated.
module waveform_shape_generator_core #(
  parameter int PHASE_BITS = wsg_pkg::PHASE_BITS_DEF,
  parameter int FRAC_BITS  = wsg_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  wsg_cfg_if.sink      cfg,
  wsg_phase_if.sink    phase,
  wsg_sample_if.source sample
);
  import wsg_pkg::*;

  localparam int RW    = 2 * FRAC_BITS + 2;
  localparam int N     = RW / 2;
  localparam int VW    = FRAC_BITS + 3;
  localparam int TAG_W = $bits(side_t);
  localparam logic signed [VW-1:0] ONE_V = {3'b001, {FRAC_BITS{1'b0}}};
  localparam int ONE_I = 1 << FRAC_BITS;

  shape_t shape;
  logic   en;

  assign cfg.ready   = 1'b1;
  assign en          = !sample.valid || sample.ready;
  assign phase.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= SHAPE_TRI;
    end else if (cfg.valid) begin
      shape <= shape_t'(cfg.shape_select);
    end
  end

  logic          f_valid;
  logic [RW-1:0] f_rad;
  side_t         f_side;

  wsg_front #(.PHASE_BITS(PHASE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (phase.valid),
    .phase     (phase.phase_in),
    .shape     (shape),
    .out_valid (f_valid),
    .rad       (f_rad),
    .side      (f_side)
  );

  logic             r_valid;
  logic [N-1:0]     r_root;
  logic [TAG_W-1:0] r_tag;
  side_t            r_side;

  wsg_isqrt #(.RAD_W(RW), .TAG_W(TAG_W)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad_in    (f_rad),
    .tag_in    (f_side),
    .out_valid (r_valid),
    .root_out  (r_root),
    .tag_out   (r_tag)
  );

  assign r_side = side_t'(r_tag);

  logic signed [VW-1:0]       v_root, v_mag;
  logic        [SAMPLE_W-1:0] sample_next;

  assign v_mag  = signed'(VW'(r_root));
  assign v_root = signed'(VW'({r_root, 1'b0})) - ONE_V;

  always_comb begin
    case (r_side.kind)
      KIND_DIRECT:   sample_next = r_side.direct;
      KIND_ROOT:     sample_next = SAMPLE_W'(v_root);
      KIND_SEMI_POS: sample_next = SAMPLE_W'(v_mag);
      KIND_SEMI_NEG: sample_next = SAMPLE_W'(-v_mag);
      default:       sample_next = r_side.direct;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else if (en) begin
      sample.valid <= r_valid;
    end
    if (en) begin
      sample.sample_out <= signed'(sample_next);
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sample.valid)
    else $error("sample valid after reset");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    sample.valid && (FRAC_BITS <= 14) |->
      (int'(sample.sample_out) >= -ONE_I) && (int'(sample.sample_out) <= ONE_I))
    else $error("sample outside unit range");

endmodule

[tb/waveform_shape_generator_core_tb.sv]
// Self-checking testbench of the waveform shape generator core.
// Depends on wsg_pkg, the three channel interfaces and the core itself;
// samples are predicted in place and compared in order of request.
`timescale 1ns / 1ps

module waveform_shape_generator_core_tb;
  import wsg_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS_DEF;
  localparam int TURN       = 1 << PHASE_BITS_DEF;
  localparam int HALF_TURN  = TURN / 2;
  localparam int EIGHTH     = TURN / 8;
  localparam int LATENCY    = FRAC_BITS_DEF + 4;
  localparam int N_RANDOM   = 1820;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PHASE_W-1:0]  phase;
    shape_t              shape;
    bit                  known;
    logic [SAMPLE_W-1:0] sample;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsg_cfg_if    cfg_ch();
  wsg_phase_if  phase_ch();
  wsg_sample_if sample_ch();

  waveform_shape_generator_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch.sink),
    .phase  (phase_ch.sink),
    .sample (sample_ch.source)
  );

  logic [SAMPLE_W-1:0] expected_samples[$];
  shape_t              cur_shape = SHAPE_TRI;
  int                  mismatches = 0;
  longint              cycles = 0;
  bit                  quiet = 1'b0;
  vec_t                vectors[$];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned round_turn(longint unsigned num);
    return (num + HALF_TURN) >> PHASE_BITS_DEF;
  endfunction

  function automatic logic [SAMPLE_W-1:0] shaped_sample(shape_t sh, logic [PHASE_W-1:0] ph);
    longint unsigned p, t, d, sq, r, w, c, span, y;
    longint s;
    bit upper;
    p = ph;
    t = (2 * p >= TURN) ? 2 * p - TURN : TURN - 2 * p;
    d = round_turn(t * ONE);
    case (sh)
      SHAPE_TRI:    s = 2 * longint'(d) - ONE;
      SHAPE_SAW:    s = ONE - longint'(round_turn(2 * p * ONE));
      SHAPE_SQUARE: s = (p < HALF_TURN) ? ONE / 2 : -(ONE / 2);
      SHAPE_PARAB: begin
        sq = (d * d + ONE / 2) >> FRAC_BITS_DEF;
        s = 2 * longint'(sq) - ONE;
      end
      SHAPE_ROOT:   s = 2 * longint'(root_floor(d * ONE)) - ONE;
      SHAPE_SOFT: begin
        if (p >= 3 * EIGHTH && p <= HALF_TURN) begin
          r = ((p - 3 * EIGHTH) * 2 * ONE + EIGHTH / 2) >> (PHASE_BITS_DEF - 3);
          s = ONE - longint'(r);
        end else if (p >= 7 * EIGHTH) begin
          r = ((p - 7 * EIGHTH) * 2 * ONE + EIGHTH / 2) >> (PHASE_BITS_DEF - 3);
          s = longint'(r) - ONE;
        end else begin
          s = (p < HALF_TURN) ? ONE : -ONE;
        end
      end
      SHAPE_BIPOLAR: s = (p < HALF_TURN) ? ONE : -ONE;
      default: begin
        w = (p + TURN / 4) % TURN;
        upper = (w <= HALF_TURN);
        c = upper ? TURN : 3 * TURN;
        span = (4 * w >= c) ? 4 * w - c : c - 4 * w;
        y = round_turn(span * ONE);
        if (y > ONE) y = ONE;
        s = longint'(root_floor(longint'(ONE) * ONE - y * y));
        if (!upper) s = -s;
      end
    endcase
    return s[SAMPLE_W-1:0];
  endfunction

  // sample side: random stall, compare at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", sample_ch.sample_out);
      end else begin
        logic [SAMPLE_W-1:0] exp_s;
        exp_s = expected_samples.pop_front();
        if (sample_ch.sample_out !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %0d got %0d",
                     $signed(exp_s), $signed(sample_ch.sample_out));
        end
      end
    end
  end

  always @(negedge clk) begin
    sample_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_phase(logic [PHASE_W-1:0] ph, bit known, logic [SAMPLE_W-1:0] smp);
    while (!quiet && $urandom_range(99) < 12) begin
      phase_ch.valid <= 1'b0;
      @(negedge clk);
    end
    phase_ch.valid    <= 1'b1;
    phase_ch.phase_in <= ph;
    do @(posedge clk); while (!phase_ch.ready);
    expected_samples.insert(expected_samples.size(),
                            known ? smp : shaped_sample(cur_shape, ph));
    @(negedge clk);
  endtask

  task automatic drain();
    phase_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_shape(shape_t sh);
    drain();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.shape_select <= sh;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_shape = sh;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_vec(logic [PHASE_W-1:0] ph, shape_t sh, bit known, int smp);
    vec_t v;
    v.phase = ph; v.shape = sh; v.known = known; v.sample = smp[SAMPLE_W-1:0];
    vectors.insert(vectors.size(), v);
  endtask

  initial begin
    shape_t sh;
    int phase_rand;
    cfg_ch.valid = 1'b0;
    cfg_ch.shape_select = SHAPE_TRI;
    phase_ch.valid = 1'b0;
    phase_ch.phase_in = '0;
    sample_ch.ready = 1'b1;

    // shape after reset is triangle
    add_vec(16'h0000, SHAPE_TRI,     1'b1,  ONE);
    add_vec(16'h8000, SHAPE_TRI,     1'b1, -ONE);
    add_vec(16'hFFFF, SHAPE_TRI,     1'b0, 0);
    add_vec(16'h0000, SHAPE_SAW,     1'b1,  ONE);
    add_vec(16'h8000, SHAPE_SAW,     1'b1,  0);
    add_vec(16'hFFFF, SHAPE_SAW,     1'b0, 0);
    add_vec(16'h7FFF, SHAPE_SQUARE,  1'b1,  ONE / 2);
    add_vec(16'h8000, SHAPE_SQUARE,  1'b1, -ONE / 2);
    add_vec(16'h0000, SHAPE_PARAB,   1'b1,  ONE);
    add_vec(16'h8000, SHAPE_PARAB,   1'b1, -ONE);
    add_vec(16'h4000, SHAPE_ROOT,    1'b0, 0);
    add_vec(16'h8000, SHAPE_ROOT,    1'b1, -ONE);
    add_vec(16'h6000, SHAPE_SOFT,    1'b1,  ONE);
    add_vec(16'h8000, SHAPE_SOFT,    1'b1, -ONE);
    add_vec(16'h7000, SHAPE_SOFT,    1'b1,  0);
    add_vec(16'hE000, SHAPE_SOFT,    1'b1, -ONE);
    add_vec(16'hFFFF, SHAPE_SOFT,    1'b0, 0);
    add_vec(16'h7FFF, SHAPE_BIPOLAR, 1'b1,  ONE);
    add_vec(16'h8000, SHAPE_BIPOLAR, 1'b1, -ONE);
    add_vec(16'h0000, SHAPE_SEMI,    1'b1,  ONE);
    add_vec(16'h4000, SHAPE_SEMI,    1'b1,  0);
    add_vec(16'h8000, SHAPE_SEMI,    1'b1, -ONE);
    add_vec(16'h5555, SHAPE_SEMI,    1'b0, 0);
    add_vec(16'hAAAA, SHAPE_SEMI,    1'b0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) begin
      if (vectors[i].shape != cur_shape) write_shape(vectors[i].shape);
      send_phase(vectors[i].phase, vectors[i].known, vectors[i].sample);
    end

    // random phases, a fresh shape every so often, one stretch with no idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) begin
        sh = shape_t'($urandom_range(7));
        write_shape(sh);
      end
      quiet = (n >= 600 && n < 800);
      case ($urandom_range(3))
        0: phase_rand = $urandom_range(16'hFFFF);
        1: phase_rand = $urandom_range(16'h7FFF, 16'h6000) + (($urandom_range(1)) ? 16'h6000 : 0);
        2: phase_rand = $urandom_range(3) ? $urandom_range(16'hFFFF) : 16'hFFFF - $urandom_range(3);
        default: phase_rand = $urandom_range(16'hFFFF);
      endcase
      if (n == 1000) drain();
      send_phase(phase_rand[PHASE_W-1:0], 1'b0, '0);
    end
    quiet = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
